FILE: src/tbc_pkg.sv
// Package for the text block classifier: field widths, byte codes,
// configuration register indexes and reset values, and byte class helpers.
// No dependencies.
package tbc_pkg;

    // Default number of bytes examined per block.
    localparam int SAMPLE_BYTES_DEF = 4096;

    // Field and register widths fixed by the interface.
    localparam int BYTE_W  = 8;
    localparam int PCT_W   = 7;
    localparam int UU_W    = 12;
    localparam int CFG_D_W = 12;
    localparam int CFG_I_W = 3;

    // Histogram entries carry this many bits of block epoch.
    localparam int EPOCH_W = 8;

    // Result queue depth and its pointer and count widths.
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    // Arithmetic constants of the verdict.
    localparam int PERCENT_SCALE = 100;
    localparam int SPACE_DIVISOR = 10;

    // Byte codes.
    localparam logic [BYTE_W-1:0] BYTE_NEWLINE  = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_TAB      = 8'h09;
    localparam logic [BYTE_W-1:0] BYTE_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] BYTE_SPACE    = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_TILDE    = 8'h7E;

    // Configuration register indexes.
    localparam logic [CFG_I_W-1:0] REG_ALWAYS_TEXT    = 3'd0;
    localparam logic [CFG_I_W-1:0] REG_CHECK_UUENCODE = 3'd1;
    localparam logic [CFG_I_W-1:0] REG_PRINT_PERCENT  = 3'd2;
    localparam logic [CFG_I_W-1:0] REG_UU_MIN_LINE    = 3'd3;
    localparam logic [CFG_I_W-1:0] REG_UU_MAX_LINE    = 3'd4;

    // Configuration reset values.
    localparam logic [PCT_W-1:0] PRINT_PERCENT_RST = 7'd95;
    localparam logic [UU_W-1:0]  UU_MIN_LINE_RST   = 12'd50;
    localparam logic [UU_W-1:0]  UU_MAX_LINE_RST   = 12'd80;

    // Whitespace in the C locale: tab through carriage return, and space.
    function automatic logic is_space_byte(input logic [BYTE_W-1:0] b);
        return ((b >= BYTE_TAB) && (b <= BYTE_CR)) || (b == BYTE_SPACE);
    endfunction

    // Printable in the C locale: space through tilde.
    function automatic logic is_print_byte(input logic [BYTE_W-1:0] b);
        return (b >= BYTE_SPACE) && (b <= BYTE_TILDE);
    endfunction

endpackage

FILE: src/text_block_classifier.sv
// Text block classifier: byte stream in, one text/binary verdict per block out.
// Depends on tbc_pkg for widths, byte codes and configuration register indexes.
//
//   Channel  Handshake                Payload                      Direction
//   -------  -----------------------  ---------------------------  ---------
//   in       in_valid / in_ready      data_byte[7:0], last         into block
//   out      out_valid / out_ready    is_text                      out of block
//   cfg      cfg_valid / cfg_ready    cfg_index[2:0], cfg_data     into block
//
// One byte item is taken per cycle while in_ready is high. The verdict of a
// block passes through stage 1 and stage 2 into the result queue after its
// last item is accepted. The line length histogram lives in one synchronous
// memory of SAMPLE_BYTES entries; a newline reads its bin at acceptance and
// writes the incremented count back in the next cycle, with forwarding between
// back-to-back newlines of equal length. Each entry is tagged with a block
// epoch, so a new block sees an empty histogram without any sweep. After
// reset, and once every 2**EPOCH_W blocks when the epoch wraps, a clearing
// pass over all SAMPLE_BYTES entries runs, during which in_ready is low.
// in_ready also drops while the result queue could not take every verdict
// already in flight, so a stalled output holds input back without losing
// anything. cfg_ready is always high.
module text_block_classifier #(
    parameter int SAMPLE_BYTES = tbc_pkg::SAMPLE_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tbc_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          is_text,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tbc_pkg::CFG_I_W-1:0]   cfg_index,
    input  logic [tbc_pkg::CFG_D_W-1:0]   cfg_data
);
    import tbc_pkg::*;

    // Counters must hold SAMPLE_BYTES itself; histogram addresses stop one short.
    localparam int CNT_W  = $clog2(SAMPLE_BYTES + 1);
    localparam int ADDR_W = $clog2(SAMPLE_BYTES);
    localparam int CMP_W  = (ADDR_W > UU_W) ? ADDR_W : UU_W;
    localparam int PROD_W = CNT_W + PCT_W + 1;
    localparam int SCL_W  = CNT_W + 4;
    localparam int ENT_W  = EPOCH_W + CNT_W;
    localparam int RES_W  = OUT_CNT_W + 1;
    localparam logic [CNT_W-1:0]  LIMIT     = CNT_W'(SAMPLE_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SAMPLE_BYTES - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic              always_text_reg;
    logic              check_uu_reg;
    logic [PCT_W-1:0]  pct_reg;
    logic [UU_W-1:0]   uu_min_reg;
    logic [UU_W-1:0]   uu_max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            always_text_reg <= 1'b0;
            check_uu_reg    <= 1'b0;
            pct_reg         <= PRINT_PERCENT_RST;
            uu_min_reg      <= UU_MIN_LINE_RST;
            uu_max_reg      <= UU_MAX_LINE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ALWAYS_TEXT:    always_text_reg <= cfg_data[0];
                REG_CHECK_UUENCODE: check_uu_reg    <= cfg_data[0];
                REG_PRINT_PERCENT:  pct_reg         <= cfg_data[PCT_W-1:0];
                REG_UU_MIN_LINE:    uu_min_reg      <= cfg_data[UU_W-1:0];
                REG_UU_MAX_LINE:    uu_max_reg      <= cfg_data[UU_W-1:0];
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    // Running block counters (stage 0).
    logic [CNT_W-1:0]  byte_cnt_reg,  byte_cnt_next;
    logic [CNT_W-1:0]  print_cnt_reg, print_cnt_next;
    logic [CNT_W-1:0]  space_cnt_reg, space_cnt_next;
    logic [CNT_W-1:0]  line_len_reg,  line_len_next;
    logic [ADDR_W-1:0] line_cnt_reg,  line_cnt_next;

    // Stage 1: histogram update, block snapshot on the last item.
    logic              s1_valid_reg;
    logic              s1_last_reg;
    logic              s1_bin_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [CNT_W-1:0]  s1_bytes_reg;
    logic [CNT_W-1:0]  s1_print_reg;
    logic [CNT_W-1:0]  s1_space_reg;
    logic [ADDR_W-1:0] s1_lines_reg;

    // Histogram memory and its access path.
    logic [ENT_W-1:0]  hist_mem [SAMPLE_BYTES];
    logic [ENT_W-1:0]  hist_rd_reg;
    logic [ADDR_W-1:0] hist_raddr;
    logic              hist_we;
    logic [ADDR_W-1:0] hist_waddr;
    logic [ENT_W-1:0]  hist_wdata;

    logic [EPOCH_W-1:0] epoch_reg;
    logic               clearing_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic               wrap_hold;

    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [CNT_W-1:0]  fwd_cnt_reg;

    logic [CNT_W-1:0]  mode_h_reg,  mode_h_next;
    logic [ADDR_W-1:0] mode_l_reg,  mode_l_next;
    logic [CNT_W-1:0]  hist_old;
    logic [CNT_W-1:0]  hist_new;

    // Stage 2: verdict inputs.
    logic              s2_valid_reg;
    logic [PROD_W-1:0] s2_pct_lhs_reg;
    logic [PROD_W-1:0] s2_pct_rhs_reg;
    logic [SCL_W-1:0]  s2_space_scl_reg;
    logic [CNT_W-1:0]  s2_bytes_reg;
    logic [ADDR_W-1:0] s2_lines_reg;
    logic [CNT_W-1:0]  s2_mode_h_reg;
    logic [ADDR_W-1:0] s2_mode_l_reg;
    logic              verdict;
    logic              uu_like;

    // Result queue.
    logic                 out_q_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] out_head_reg;
    logic [OUT_PTR_W-1:0] out_tail_reg;
    logic [OUT_CNT_W-1:0] out_cnt_reg;
    logic [RES_W-1:0]     reserved;
    logic                 push;
    logic                 pop;

    logic take;
    logic counted;
    logic is_nl;
    logic bin;

    // ------------------------------------------------------------------
    // Input acceptance
    // ------------------------------------------------------------------
    // The wrap hold keeps the first item of the next block out while the
    // last block of an epoch is still in stage 1 and the sweep is about to start.
    assign wrap_hold = s1_valid_reg && s1_last_reg && (&epoch_reg);
    assign reserved  = RES_W'(out_cnt_reg) + RES_W'(s1_valid_reg && s1_last_reg)
                     + RES_W'(s2_valid_reg);
    assign in_ready  = !clearing_reg && !wrap_hold && (reserved < RES_W'(OUT_DEPTH));
    assign take      = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Stage 0: byte classes and running counters
    // ------------------------------------------------------------------
    assign counted = take && (byte_cnt_reg < LIMIT);
    assign is_nl   = (data_byte == BYTE_NEWLINE);
    assign bin     = counted && is_nl;

    always_comb
    begin
        byte_cnt_next  = byte_cnt_reg;
        print_cnt_next = print_cnt_reg;
        space_cnt_next = space_cnt_reg;
        line_len_next  = line_len_reg;
        line_cnt_next  = line_cnt_reg;
        if (counted)
        begin
            byte_cnt_next = byte_cnt_reg + CNT_W'(1);
            if (is_print_byte(data_byte) || is_space_byte(data_byte))
            begin
                print_cnt_next = print_cnt_reg + CNT_W'(1);
            end
            if (is_space_byte(data_byte))
            begin
                space_cnt_next = space_cnt_reg + CNT_W'(1);
            end
            if (is_nl)
            begin
                line_len_next = '0;
                if (line_cnt_reg != LAST_ADDR)
                begin
                    line_cnt_next = line_cnt_reg + ADDR_W'(1);
                end
            end
            else
            begin
                line_len_next = line_len_reg + CNT_W'(1);
            end
        end
    end

    // The finished line's bin; lengths at or past the limit share the top bin.
    assign hist_raddr = (line_len_reg >= LIMIT) ? LAST_ADDR : line_len_reg[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg  <= '0;
            print_cnt_reg <= '0;
            space_cnt_reg <= '0;
            line_len_reg  <= '0;
            line_cnt_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s1_bin_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            s1_last_reg  <= take && last;
            s1_bin_reg   <= bin;
            if (take && last)
            begin
                byte_cnt_reg  <= '0;
                print_cnt_reg <= '0;
                space_cnt_reg <= '0;
                line_len_reg  <= '0;
                line_cnt_reg  <= '0;
            end
            else
            begin
                byte_cnt_reg  <= byte_cnt_next;
                print_cnt_reg <= print_cnt_next;
                space_cnt_reg <= space_cnt_next;
                line_len_reg  <= line_len_next;
                line_cnt_reg  <= line_cnt_next;
            end
        end
    end

    // Block totals travel with the last item.
    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= hist_raddr;
        s1_bytes_reg <= byte_cnt_next;
        s1_print_reg <= print_cnt_next;
        s1_space_reg <= space_cnt_next;
        s1_lines_reg <= line_cnt_next;
    end

    // ------------------------------------------------------------------
    // Histogram memory
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rd_reg <= hist_mem[hist_raddr];
    end

    // ------------------------------------------------------------------
    // Stage 1: read-modify-write of the bin and the running mode
    // ------------------------------------------------------------------
    always_comb
    begin
        // An entry from an older epoch counts as empty. A write to the same
        // bin in the previous cycle has not reached the read data yet.
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            hist_old = fwd_cnt_reg;
        end
        else if (hist_rd_reg[ENT_W-1:CNT_W] == epoch_reg)
        begin
            hist_old = hist_rd_reg[CNT_W-1:0];
        end
        else
        begin
            hist_old = '0;
        end
        hist_new = hist_old + CNT_W'(1);

        // Most frequent length: ties go to the shorter line.
        mode_h_next = mode_h_reg;
        mode_l_next = mode_l_reg;
        if (s1_bin_reg)
        begin
            if (hist_new > mode_h_reg)
            begin
                mode_h_next = hist_new;
                mode_l_next = s1_addr_reg;
            end
            else if ((hist_new == mode_h_reg) && (s1_addr_reg < mode_l_reg))
            begin
                mode_l_next = s1_addr_reg;
            end
        end
    end

    assign hist_we    = clearing_reg || (s1_valid_reg && s1_bin_reg);
    assign hist_waddr = clearing_reg ? clr_addr_reg : s1_addr_reg;
    assign hist_wdata = clearing_reg ? '0 : {epoch_reg, hist_new};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_h_reg    <= '0;
            mode_l_reg    <= '0;
            fwd_valid_reg <= 1'b0;
            epoch_reg     <= '0;
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s1_valid_reg && s1_last_reg;
            fwd_valid_reg <= s1_valid_reg && s1_bin_reg && !s1_last_reg;

            if (s1_valid_reg && s1_last_reg)
            begin
                mode_h_reg <= '0;
                mode_l_reg <= '0;
                epoch_reg  <= epoch_reg + EPOCH_W'(1);
                if (&epoch_reg)
                begin
                    clearing_reg <= 1'b1;
                end
            end
            else if (s1_valid_reg)
            begin
                mode_h_reg <= mode_h_next;
                mode_l_reg <= mode_l_next;
            end

            // Sweep every entry back to an empty count.
            if (clearing_reg)
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clearing_reg <= 1'b0;
                    clr_addr_reg <= '0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                end
            end
        end
    end

    // Verdict operands. The percent test floor(100*p/n) <= pct is done as
    // 100*p < (pct+1)*n, and space < floor(n/10) as 10*space + 10 <= n.
    always_ff @(posedge clk)
    begin
        fwd_addr_reg     <= s1_addr_reg;
        fwd_cnt_reg      <= hist_new;
        s2_pct_lhs_reg   <= PROD_W'(s1_print_reg) * PROD_W'(PERCENT_SCALE);
        s2_pct_rhs_reg   <= (PROD_W'(pct_reg) + PROD_W'(1)) * PROD_W'(s1_bytes_reg);
        s2_space_scl_reg <= (SCL_W'(s1_space_reg) + SCL_W'(1)) * SCL_W'(SPACE_DIVISOR);
        s2_bytes_reg     <= s1_bytes_reg;
        s2_lines_reg     <= s1_lines_reg;
        s2_mode_h_reg    <= mode_h_next;
        s2_mode_l_reg    <= mode_l_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: verdict
    // ------------------------------------------------------------------
    always_comb
    begin
        uu_like = check_uu_reg
               && (s2_mode_h_reg > CNT_W'(s2_lines_reg >> 1))
               && (s2_space_scl_reg <= SCL_W'(s2_bytes_reg))
               && (CMP_W'(s2_mode_l_reg) >= CMP_W'(uu_min_reg))
               && (CMP_W'(s2_mode_l_reg) <= CMP_W'(uu_max_reg));
        if (always_text_reg)
        begin
            verdict = 1'b1;
        end
        else if (s2_bytes_reg == '0)
        begin
            verdict = 1'b0;
        end
        else if (s2_pct_lhs_reg < s2_pct_rhs_reg)
        begin
            verdict = 1'b0;
        end
        else
        begin
            verdict = !uu_like;
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    assign push      = s2_valid_reg;
    assign pop       = out_valid && out_ready;
    assign out_valid = (out_cnt_reg != '0);
    assign is_text   = out_q_reg[out_head_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_q_reg[out_tail_reg] <= verdict;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_head_reg <= '0;
            out_tail_reg <= '0;
            out_cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                out_tail_reg <= out_tail_reg + OUT_PTR_W'(1);
            end
            if (pop)
            begin
                out_head_reg <= out_head_reg + OUT_PTR_W'(1);
            end
            if (push && !pop)
            begin
                out_cnt_reg <= out_cnt_reg + OUT_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                out_cnt_reg <= out_cnt_reg - OUT_CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Every verdict in flight has a queue slot waiting for it.
    assert property (@(posedge clk) disable iff (!rst_n) reserved <= RES_W'(OUT_DEPTH))
        else $error("result queue reservation exceeded");

    // No histogram update may collide with the clearing sweep.
    assert property (@(posedge clk) disable iff (!rst_n) clearing_reg |-> !s1_valid_reg)
        else $error("item in stage 1 during clearing sweep");

    // The end of the last block of an epoch starts the sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg && (&epoch_reg)) |=> clearing_reg)
        else $error("epoch wrapped without clearing sweep");

    // Forwarding only links two newlines of the same block.
    assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> $past(s1_valid_reg && !s1_last_reg))
        else $error("forwarding across a block boundary");

endmodule

FILE: tb/tb_text_block_classifier.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_block_classifier: byte items in, one verdict per block out.
// Depends on tbc_pkg for widths, byte codes and register indexes, and on the block itself.
// It runs a directed table, random blocks under several register settings, then back pressure.
module tb_text_block_classifier;
    import tbc_pkg::*;

    localparam int  SAMPLE_BYTES     = SAMPLE_BYTES_DEF;
    localparam int  CNT_W            = $clog2(SAMPLE_BYTES + 1);
    localparam int  CLK_PERIOD       = 8;
    localparam int  RESET_CYCLES     = 11;
    // The verdict goes through stage 1, stage 2 and the result queue; allow a margin.
    localparam int  DRAIN_CYCLES     = 8;
    localparam int  LONG_HOLD_CYCLES = 400;
    // The clearing pass after reset alone sweeps all SAMPLE_BYTES entries, and the
    // longest correct run stays far below this limit.
    localparam int  TIMEOUT_NS       = 3_000_000;
    localparam logic [CFG_I_W-1:0] REG_PAST_LAST = 3'd5;

    // Kinds of random block.
    typedef enum int {
        BLK_TEXT,
        BLK_UU,
        BLK_NOISE
    } blk_kind_t;

    // One row of the directed table. Where fixed is set, want holds the
    // verdict read straight off the rules; otherwise the predictor decides.
    typedef struct packed {
        logic [BYTE_W-1:0] code;
        logic              fin;
        logic              fixed;
        logic              want;
    } dir_row_t;

    localparam int DIR_N = 21;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    data_byte = '0;
    logic                 last      = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 is_text;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_I_W-1:0]   cfg_index = '0;
    logic [CFG_D_W-1:0]   cfg_data  = '0;

    // Verdict carried by the item on the input port when it is in the table.
    logic                 item_fixed     = 1'b0;
    logic                 item_fixed_val = 1'b0;

    // Idling controls. The receiver owns its long hold counter.
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    logic                 long_hold      = 1'b0;
    int                   hold_left      = 0;
    bit                   hold_used      = 1'b0;

    int                   fails = 0;

    // Verdicts still to come out of the block, oldest first.
    logic                 verdict_q[$];

    // Predictor copy of the registers.
    logic                 cfg_force;
    logic                 cfg_uu;
    logic [PCT_W-1:0]     cfg_pct;
    logic [UU_W-1:0]      cfg_uu_min;
    logic [UU_W-1:0]      cfg_uu_max;

    // Predictor copy of the block state.
    logic [CNT_W-1:0]     n_bytes;
    logic [CNT_W-1:0]     n_print;
    logic [CNT_W-1:0]     n_space;
    logic [CNT_W-1:0]     line_len;
    logic [CNT_W-1:0]     n_lines;
    logic [CNT_W-1:0]     peak_height;
    logic [UU_W-1:0]      peak_len;
    logic [CNT_W-1:0]     line_hist [SAMPLE_BYTES];

    logic                 has_verdict;
    logic                 verdict_now;

    dir_row_t dir_rows [DIR_N] = '{
        '{8'h41,        1'b1, 1'b1, 1'b1},   // a letter alone is text
        '{8'h00,        1'b1, 1'b1, 1'b0},   // NUL is neither class
        '{8'hFF,        1'b1, 1'b1, 1'b0},   // top byte value
        '{8'h7E,        1'b1, 1'b1, 1'b1},   // highest printable
        '{8'h7F,        1'b1, 1'b1, 1'b0},   // DEL just above it
        '{8'h09,        1'b1, 1'b1, 1'b1},   // tab, lowest whitespace
        '{8'h0D,        1'b1, 1'b1, 1'b1},   // carriage return, highest control whitespace
        '{8'h0E,        1'b1, 1'b1, 1'b0},
        '{8'h1F,        1'b1, 1'b1, 1'b0},
        '{8'h20,        1'b1, 1'b1, 1'b1},   // space is both classes
        '{8'h80,        1'b1, 1'b1, 1'b0},   // high bytes are neither class
        '{BYTE_NEWLINE, 1'b1, 1'b1, 1'b1},
        '{8'h61,        1'b0, 1'b0, 1'b0},
        '{8'h62,        1'b0, 1'b0, 1'b0},
        '{BYTE_NEWLINE, 1'b0, 1'b0, 1'b0},
        '{8'h63,        1'b0, 1'b0, 1'b0},
        '{BYTE_NEWLINE, 1'b0, 1'b0, 1'b0},
        '{8'h08,        1'b1, 1'b0, 1'b0},   // backspace closes a block with an open line
        '{BYTE_NEWLINE, 1'b0, 1'b0, 1'b0},
        '{BYTE_NEWLINE, 1'b0, 1'b0, 1'b0},
        '{8'h78,        1'b1, 1'b0, 1'b0}    // two empty lines, then an unfinished one
    };

    text_block_classifier #(
        .SAMPLE_BYTES (SAMPLE_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_text   (is_text),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Wipes the per-block counters and the line length histogram.
    task automatic clear_block();
        n_bytes     = '0;
        n_print     = '0;
        n_space     = '0;
        line_len    = '0;
        n_lines     = '0;
        peak_height = '0;
        peak_len    = '0;
        foreach (line_hist[i])
            line_hist[i] = '0;
    endtask

    // Folds one accepted byte into the block state. On the closing byte it
    // forms the verdict and starts a fresh block.
    task automatic predict_item(input logic [BYTE_W-1:0] b, input logic fin,
                                output logic got_verdict, output logic verdict);
        int               bin;
        int               pct_now;
        logic [CNT_W-1:0] height;
        logic             ws;
        got_verdict = fin;
        verdict = 1'b0;
        ws = ((b >= BYTE_TAB) && (b <= BYTE_CR)) || (b == BYTE_SPACE);
        // Bytes past the sample limit are dropped, though their flag still counts.
        if (int'(n_bytes) < SAMPLE_BYTES) begin
            n_bytes++;
            if (ws || ((b >= BYTE_SPACE) && (b <= BYTE_TILDE)))
                n_print++;
            if (ws)
                n_space++;
            if (b == BYTE_NEWLINE) begin
                bin = (int'(line_len) >= SAMPLE_BYTES) ? SAMPLE_BYTES - 1 : int'(line_len);
                height = line_hist[bin] + 1'b1;
                line_hist[bin] = height;
                // The mode is the most frequent length, the shortest one on a tie.
                if (height > peak_height) begin
                    peak_height = height;
                    peak_len = UU_W'(bin);
                end else if ((height == peak_height) && (bin < int'(peak_len))) begin
                    peak_len = UU_W'(bin);
                end
                if (int'(n_lines) < SAMPLE_BYTES - 1)
                    n_lines++;
                line_len = '0;
            end else begin
                line_len++;
            end
        end
        if (fin) begin
            if (cfg_force) begin
                verdict = 1'b1;
            end else if (n_bytes == '0) begin
                verdict = 1'b0;
            end else begin
                pct_now = (PERCENT_SCALE * int'(n_print)) / int'(n_bytes);
                if (pct_now <= int'(cfg_pct))
                    verdict = 1'b0;
                else if (cfg_uu && (peak_height > n_lines / 2)
                         && (int'(n_space) < int'(n_bytes) / SPACE_DIVISOR)
                         && (peak_len >= cfg_uu_min) && (peak_len <= cfg_uu_max))
                    verdict = 1'b0;
                else
                    verdict = 1'b1;
            end
            clear_block();
        end
    endtask

    // All three channels are sampled at the falling edge. Everything the
    // testbench drives changes at the rising edge, and the block's outputs
    // settle right after it, so these values are the ones the next rising
    // edge acts on.
    always @(negedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ALWAYS_TEXT:    cfg_force  = cfg_data[0];
                    REG_CHECK_UUENCODE: cfg_uu     = cfg_data[0];
                    REG_PRINT_PERCENT:  cfg_pct    = cfg_data[PCT_W-1:0];
                    REG_UU_MIN_LINE:    cfg_uu_min = cfg_data[UU_W-1:0];
                    REG_UU_MAX_LINE:    cfg_uu_max = cfg_data[UU_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                predict_item(data_byte, last, has_verdict, verdict_now);
                if (has_verdict)
                    verdict_q.push_back(item_fixed ? item_fixed_val : verdict_now);
            end
            if (out_valid && out_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: result with no verdict waiting, is_text=%0b",
                             $time, is_text);
                    fails++;
                end else begin
                    if (is_text !== verdict_q[0]) begin
                        $display("%0t: is_text mismatch, expected %0b, actual %0b",
                                 $time, verdict_q[0], is_text);
                        fails++;
                    end
                    void'(verdict_q.pop_front());
                end
            end
        end
    end

    // Receiver. One long hold is taken when asked for, so that the result
    // queue fills and the block has to stop taking bytes.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else if (long_hold && !hold_used) begin
            hold_used = 1'b1;
            hold_left = LONG_HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one byte item and returns at the rising edge that accepts it.
    // Entered and left at a rising edge; valid stays up for a following item.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fin,
                             input logic fixed, input logic fixed_val);
        bit took;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        last           <= fin;
        item_fixed     <= fixed;
        item_fixed_val <= fixed_val;
        do begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end while (!took);
    endtask

    task automatic write_reg(input logic [CFG_I_W-1:0] idx, input logic [CFG_D_W-1:0] value);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end while (!took);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Lowers valid, waits for every outstanding verdict, then lets the
    // pipeline run empty so the block is idle.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (verdict_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Builds one random block of the given kind and sends it. Uuencode-like
    // blocks are runs of equal lines without spaces, the line length drawn
    // from lo..hi; some of them are spoiled so the test narrowly misses.
    task automatic send_random_block(input blk_kind_t kind, input int lo, input int hi,
                                     output int n_sent);
        logic [BYTE_W-1:0] blk[$];
        int                n_rows;
        int                row_len;
        int                roll;
        case (kind)
            BLK_TEXT: begin
                repeat ($urandom_range(24, 1)) begin
                    roll = $urandom_range(99);
                    if (roll < 60)
                        blk.push_back(BYTE_W'($urandom_range(BYTE_TILDE, BYTE_SPACE + 1)));
                    else if (roll < 75)
                        blk.push_back(BYTE_SPACE);
                    else if (roll < 90)
                        blk.push_back(BYTE_NEWLINE);
                    else if (roll < 95)
                        blk.push_back(BYTE_W'($urandom_range(BYTE_CR, BYTE_TAB)));
                    else
                        blk.push_back(BYTE_W'($urandom_range(255)));
                end
            end
            BLK_UU: begin
                n_rows = $urandom_range(4, 2);
                row_len = $urandom_range(hi, lo);
                for (int r = 0; r < n_rows; r++) begin
                    // One row in five gets another length.
                    roll = ($urandom_range(4) == 0) ? $urandom_range(hi, lo) : row_len;
                    for (int c = 0; c < roll; c++)
                        blk.push_back(BYTE_W'($urandom_range(BYTE_TILDE, BYTE_SPACE + 1)));
                    if ((roll > 0) && ($urandom_range(9) == 0))
                        blk[blk.size() - 1] = BYTE_SPACE;
                    blk.push_back(BYTE_NEWLINE);
                end
                // Sometimes an unfinished trailing line, which is never binned.
                if ($urandom_range(4) == 0) begin
                    repeat ($urandom_range(3, 1))
                        blk.push_back(BYTE_W'($urandom_range(BYTE_TILDE, BYTE_SPACE + 1)));
                end
            end
            default: begin
                repeat ($urandom_range(6, 1))
                    blk.push_back(BYTE_W'($urandom_range(255)));
            end
        endcase
        foreach (blk[i])
            push_byte(blk[i], (i == blk.size() - 1), 1'b0, 1'b0);
        n_sent = blk.size();
    endtask

    // One phase: wait until idle, load all registers (plus a write to an
    // index past the list, which must change nothing), set the idling, and
    // send random blocks until the byte goal is met.
    task automatic run_phase(input logic force_text, input logic uu_on,
                             input logic [PCT_W-1:0] pct,
                             input logic [UU_W-1:0] uu_lo, input logic [UU_W-1:0] uu_hi,
                             input int send_pct, input int recv_pct,
                             input int item_goal, input int len_lo, input int len_hi);
        logic [CFG_D_W-1:0] d;
        int                 sent;
        int                 n;
        int                 roll;
        drain_results();
        d = CFG_D_W'($urandom);
        d[0] = force_text;
        write_reg(REG_ALWAYS_TEXT, d);
        d = CFG_D_W'($urandom);
        d[0] = uu_on;
        write_reg(REG_CHECK_UUENCODE, d);
        d = CFG_D_W'($urandom);
        d[PCT_W-1:0] = pct;
        write_reg(REG_PRINT_PERCENT, d);
        write_reg(REG_UU_MIN_LINE, uu_lo);
        write_reg(REG_UU_MAX_LINE, uu_hi);
        write_reg(REG_PAST_LAST + CFG_I_W'($urandom_range(2)), CFG_D_W'($urandom));
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < item_goal) begin
            roll = $urandom_range(99);
            if (roll < 45)
                send_random_block(BLK_TEXT, len_lo, len_hi, n);
            else if (roll < 75)
                send_random_block(BLK_UU, len_lo, len_hi, n);
            else
                send_random_block(BLK_NOISE, len_lo, len_hi, n);
            sent += n;
        end
    endtask

    initial begin
        int idle_sel;
        int n;
        int send_opts[4];
        int recv_opts[4];
        send_opts = '{0, 82, 0, 10};
        recv_opts = '{0, 0, 82, 10};

        // Registers and block state as they come out of reset.
        cfg_force  = 1'b0;
        cfg_uu     = 1'b0;
        cfg_pct    = PRINT_PERCENT_RST;
        cfg_uu_min = UU_MIN_LINE_RST;
        cfg_uu_max = UU_MAX_LINE_RST;
        clear_block();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset settings. The block runs its
        // clearing pass first; push_byte simply waits for in_ready.
        foreach (dir_rows[i])
            push_byte(dir_rows[i].code, dir_rows[i].fin, dir_rows[i].fixed, dir_rows[i].want);

        // Uuencode test at its reset window, long lines, no idling.
        run_phase(1'b0, 1'b1, 7'd95, 12'd50, 12'd80, 0, 0, 80, 46, 84);
        // Forced text with the lowest percentage; the sender idles.
        run_phase(1'b1, 1'b1, 7'd0, 12'd0, 12'd4095, 82, 0, 50, 0, 10);
        // Widest uuencode window; the receiver stalls.
        run_phase(1'b0, 1'b1, 7'd0, 12'd0, 12'd4095, 0, 82, 60, 0, 10);
        // Percentage above 100: nothing is text. Both sides idle a little.
        run_phase(1'b0, 1'b0, 7'd127, 12'hFFF, 12'hFFF, 10, 10, 50, 0, 10);
        // Minimum above maximum: the uuencode test can never fire.
        run_phase(1'b0, 1'b1, 7'd100, 12'd80, 12'd50, 0, 0, 50, 0, 10);
        // Random settings and a random idling mode.
        idle_sel = $urandom_range(3);
        n = $urandom_range(6);
        run_phase(1'($urandom_range(3) == 0), 1'b1, PCT_W'($urandom_range(100)),
                  UU_W'(n), UU_W'(n + $urandom_range(8)),
                  send_opts[idle_sel], recv_opts[idle_sel], 60, 0, 16);

        // Back pressure: the receiver holds off for a long stretch while the
        // sender keeps offering short blocks, so the result queue fills up.
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold <= 1'b1;
        repeat (30)
            send_random_block(BLK_NOISE, 0, 0, n);

        drain_results();
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
src/tbc_pkg.sv
src/text_block_classifier.sv
tb/tb_text_block_classifier.sv
